// ----- rtl/qlrp_pkg.sv -----
// Shared types and constants of the quantized linear recurrence pool.
// Used by every module of the block; depends on nothing else.
package qlrp_pkg;

    localparam int QLRP_NUM_CHANNELS = 256;

    localparam int CODE_W     = 8;
    localparam int SCALE_W    = 24;
    localparam int STATE_W    = 32;
    localparam int OPND_W     = 34;
    localparam int PROD_W     = 66;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MULT_SCALE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_ZERO     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_SCALE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_ZERO      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_INV_SCALE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ZERO      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_INV_SCALE = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_ZERO      = 8'd7;

    // 1.0 in unsigned Q8.16.
    localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h01_0000;

    typedef struct packed {
        logic [SCALE_W-1:0] mult_scale;
        logic [CODE_W-1:0]  mult_zero;
        logic [SCALE_W-1:0] add_scale;
        logic [CODE_W-1:0]  add_zero;
        logic [SCALE_W-1:0] out_inv_scale;
        logic [CODE_W-1:0]  out_zero;
        logic [SCALE_W-1:0] fin_inv_scale;
        logic [CODE_W-1:0]  fin_zero;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEQ,
        ST_MUL,
        ST_ACC,
        ST_REQ_OUT,
        ST_REQ_FIN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_RECUR,
        MUL_REQ_OUT,
        MUL_REQ_FIN
    } mul_sel_t;

    typedef struct packed {
        logic     clear_wr;
        logic     accept;
        logic     deq;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc;
        logic     step_latch;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/qlrp_cfg.sv -----
// Configuration register file of the quantized linear recurrence pool.
// Depends on qlrp_pkg for the register indexes and the cfg_t record.
module qlrp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qlrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qlrp_pkg::CFG_DATA_W-1:0] cfg_data,
    output qlrp_pkg::cfg_t                 cfg
);
    import qlrp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes never stall.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MULT_SCALE:    cfg_next.mult_scale    = cfg_data;
                REG_MULT_ZERO:     cfg_next.mult_zero     = cfg_data[CODE_W-1:0];
                REG_ADD_SCALE:     cfg_next.add_scale     = cfg_data;
                REG_ADD_ZERO:      cfg_next.add_zero      = cfg_data[CODE_W-1:0];
                REG_OUT_INV_SCALE: cfg_next.out_inv_scale = cfg_data;
                REG_OUT_ZERO:      cfg_next.out_zero      = cfg_data[CODE_W-1:0];
                REG_FIN_INV_SCALE: cfg_next.fin_inv_scale = cfg_data;
                REG_FIN_ZERO:      cfg_next.fin_zero      = cfg_data[CODE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mult_scale    <= SCALE_ONE;
            cfg_reg.mult_zero     <= '0;
            cfg_reg.add_scale     <= SCALE_ONE;
            cfg_reg.add_zero      <= '0;
            cfg_reg.out_inv_scale <= SCALE_ONE;
            cfg_reg.out_zero      <= '0;
            cfg_reg.fin_inv_scale <= SCALE_ONE;
            cfg_reg.fin_zero      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/qlrp_ctrl.sv -----
// Sequencing state machine of the quantized linear recurrence pool.
// Depends on qlrp_pkg for the state, command and status types.
module qlrp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qlrp_pkg::dp_status_t status,
    output qlrp_pkg::dp_cmd_t    cmd
);
    import qlrp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:    if (in_valid) state_next = ST_DEQ;
            ST_DEQ:     state_next = ST_MUL;
            ST_MUL:     state_next = ST_ACC;
            ST_ACC:     state_next = ST_REQ_OUT;
            ST_REQ_OUT: state_next = ST_REQ_FIN;
            ST_REQ_FIN: state_next = ST_DONE;
            ST_DONE:    if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DEQ:
            begin
                cmd.deq = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RECUR;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_REQ_OUT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_REQ_OUT;
            end
            ST_REQ_FIN:
            begin
                cmd.step_latch = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_REQ_FIN;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/qlrp_dp.sv -----
// Datapath of the quantized linear recurrence pool: state memory, dequantizers,
// shared signed multiplier, accumulate and requantize logic, output register.
// Depends on qlrp_pkg for widths, the cfg_t record and the command types.
module qlrp_dp #(
    parameter int NUM_CHANNELS = qlrp_pkg::QLRP_NUM_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qlrp_pkg::dp_cmd_t              cmd,
    output qlrp_pkg::dp_status_t           status,
    input  qlrp_pkg::cfg_t                 cfg,
    input  logic [qlrp_pkg::IN_DATA_W-1:0]  in_data,
    input  logic                           in_first,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [qlrp_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_final
);
    import qlrp_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Product plus {zero point, rounding term} in one add; the result from
    // bit 32 up is the rounded code, clamped to 0..255.
    function automatic logic [CODE_W-1:0] requant(input logic signed [PROD_W-1:0] p,
                                                  input logic [CODE_W-1:0]       zero);
        logic signed [PROD_W-1:0] k;
        logic signed [PROD_W-1:0] s;
        logic [PROD_W-33:0]       v;
        k = {26'b0, zero, (p[PROD_W-1] ? 32'h7FFF_FFFF : 32'h8000_0000)};
        s = p + k;
        v = s[PROD_W-1:32];
        if (v[PROD_W-33])
        begin
            requant = '0;
        end
        else if (|v[PROD_W-34:CODE_W])
        begin
            requant = '1;
        end
        else
        begin
            requant = v[CODE_W-1:0];
        end
    endfunction

    logic [STATE_W-1:0] mem [NUM_CHANNELS];

    logic [AW-1:0]              clr_addr_reg;
    logic [CODE_W-1:0]          mcode_reg;
    logic [CODE_W-1:0]          acode_reg;
    logic [CODE_W-1:0]          ch_reg;
    logic                       first_reg;
    logic                       last_reg;
    logic                       range_reg;
    logic [STATE_W-1:0]         rd_data_reg;
    logic signed [OPND_W-1:0]   m_reg;
    logic signed [OPND_W-1:0]   c_reg;
    logic signed [STATE_W-1:0]  old_reg;
    logic signed [STATE_W-1:0]  st_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [CODE_W-1:0]          step_code_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic                       out_final_reg;
    logic                       out_valid_reg;

    logic [CODE_W-1:0]          in_ch;
    logic [AW-1:0]              in_idx;
    logic                       in_range;
    logic signed [CODE_W:0]     dm;
    logic signed [CODE_W:0]     dc;
    logic signed [OPND_W-1:0]   m_next;
    logic signed [OPND_W-1:0]   c_next;
    logic signed [STATE_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   acc_k;
    logic signed [PROD_W-1:0]   acc_sum;
    logic [PROD_W-17:0]         acc_nv;
    logic [STATE_W-1:0]         state_next;
    logic                       mem_wr;
    logic [AW-1:0]              mem_wr_idx;
    logic [STATE_W-1:0]         mem_wr_data;
    logic [CODE_W-1:0]          final_code;

    assign in_ch    = in_data[3*CODE_W-1:2*CODE_W];
    assign in_idx   = AW'(in_ch);
    assign in_range = 32'(in_ch) < 32'(NUM_CHANNELS);

    assign status.clear_last = (clr_addr_reg == AW'(NUM_CHANNELS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    // Dequantization: (code - zero) * scale, exact in signed Q.16.
    assign dm     = $signed({1'b0, mcode_reg}) - $signed({1'b0, cfg.mult_zero});
    assign dc     = $signed({1'b0, acode_reg}) - $signed({1'b0, cfg.add_zero});
    assign m_next = OPND_W'(dm) * OPND_W'($signed({1'b0, cfg.mult_scale}));
    assign c_next = OPND_W'(dc) * OPND_W'($signed({1'b0, cfg.add_scale}));

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RECUR:
            begin
                mul_a = old_reg;
                mul_b = m_reg;
            end
            MUL_REQ_OUT:
            begin
                mul_a = st_reg;
                mul_b = $signed({10'b0, cfg.out_inv_scale});
            end
            MUL_REQ_FIN:
            begin
                mul_a = st_reg;
                mul_b = $signed({10'b0, cfg.fin_inv_scale});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // old * m rounded half away from zero to Q.16, with c folded into the
    // same add since its low 16 bits are zero.
    assign acc_k   = {{16{c_reg[OPND_W-1]}}, c_reg,
                      (prod_reg[PROD_W-1] ? 16'h7FFF : 16'h8000)};
    assign acc_sum = prod_reg + acc_k;
    assign acc_nv  = acc_sum[PROD_W-1:16];

    always_comb
    begin
        if (acc_nv[PROD_W-17:STATE_W-1] == {(PROD_W-16-STATE_W+1){acc_nv[PROD_W-17]}})
        begin
            state_next = acc_nv[STATE_W-1:0];
        end
        else if (acc_nv[PROD_W-17])
        begin
            state_next = 32'h8000_0000;
        end
        else
        begin
            state_next = 32'h7FFF_FFFF;
        end
    end

    assign mem_wr      = cmd.clear_wr || (cmd.acc && range_reg);
    assign mem_wr_idx  = cmd.clear_wr ? clr_addr_reg : AW'(ch_reg);
    assign mem_wr_data = cmd.clear_wr ? '0 : state_next;

    assign final_code = last_reg ? requant(prod_reg, cfg.fin_zero) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_wr_idx] <= mem_wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mcode_reg <= in_data[CODE_W-1:0];
            acode_reg <= in_data[2*CODE_W-1:CODE_W];
            ch_reg    <= in_ch;
            first_reg <= in_first;
            last_reg  <= in_last;
            range_reg <= in_range;
        end
        if (cmd.deq)
        begin
            m_reg   <= m_next;
            c_reg   <= c_next;
            old_reg <= (first_reg || !range_reg) ? '0 : $signed(rd_data_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc)
        begin
            st_reg <= $signed(state_next);
        end
        if (cmd.step_latch)
        begin
            step_code_reg <= requant(prod_reg, cfg.out_zero);
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= {final_code, step_code_reg, ch_reg};
            out_final_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_final = out_final_reg;

endmodule

// ----- rtl/quantized_linear_recurrence_pool.sv -----
// Top level of the quantized linear recurrence pool.
// Depends on qlrp_pkg, qlrp_cfg, qlrp_ctrl and qlrp_dp.
//
// Each input transaction on s_axis carries one channel element of one time
// step: multiplier code, constant code and channel index in tdata, the
// first-step flag in tuser and the last-step mark in tlast. The block
// dequantizes both codes, updates that channel's Q15.16 state to state * m + c
// (old state taken as zero on the first step or for a channel at or beyond
// NUM_CHANNELS, where nothing is stored) and returns one m_axis transaction
// with the channel, the new state requantized to uint8 and, on the last step,
// the final-state code with tuser set. Registers are written on the cfg channel,
// one per transaction; the user must write them only while no element is in
// flight, which the block itself does not enforce; cfg_ready is high. One
// element is in flight at a time. Its result shows when the input side opens
// again, so a new element is taken only once the last has passed its steps:
// the accepting cycle, dequantize, recurrence product, accumulate, two
// requantizing products on the one shared 32x34 multiplier, and the output
// load. After reset a clearing pass zeroes the state memory with s_axis_tready
// low. A stalled receiver leaves the result in the output register; the next
// element runs but holds before its output load until that register drains.
module quantized_linear_recurrence_pool #(
    parameter int NUM_CHANNELS = qlrp_pkg::QLRP_NUM_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mult_code [7:0], add_code [15:8], channel [23:16]
    input  logic [qlrp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // first_step [0]
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_channel [7:0], step_code [15:8], final_code [23:16]
    output logic [qlrp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // final_valid [0]
    output logic [0:0]                      m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qlrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qlrp_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Register file; writes are registered.
    qlrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Steps one element through dequantize, multiply, accumulate and the two
    // requantizations, and runs the clearing pass after reset.
    qlrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qlrp_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .in_data   (s_axis_tdata),
        .in_first  (s_axis_tuser[0]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_final (m_axis_tuser[0])
    );

endmodule

// ----- rtl/qlrp_checker.sv -----
// Port-level checks of the quantized linear recurrence pool, bound to the
// top level. Depends only on the top level's ports.
module qlrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // Only one element is in flight, so the input closes after a transaction.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an element is in flight");

    // A new result is loaded only while the input side is closed.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an element in flight");

    // The final-state code is zero unless the final flag is set.
    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[23:16] == 8'd0))
        else $error("final code nonzero on a non-final result");

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input open before the state memory is cleared");

endmodule

bind quantized_linear_recurrence_pool qlrp_checker u_qlrp_checker (.*);

// ----- bench/tb_quantized_linear_recurrence_pool.sv -----
// Self-checking testbench for the quantized linear recurrence pool.
// Uses qlrp_pkg for widths and register indexes and needs only the block's RTL.
// A directed table runs first, then random element sequences under several register settings.
module tb_quantized_linear_recurrence_pool;
    import qlrp_pkg::*;

    // The predictor keeps one Q15.16 state per channel, like the block.
    localparam int DEPTH = QLRP_NUM_CHANNELS;
    localparam int NUM_REGS = 8;
    // Indexes outside the register list; writes to them must leave every
    // register unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LIST = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    // The slowest legal element adds a sender gap and a receiver stall to the
    // block's own steps; over all elements and the clearing pass this limit
    // leaves ample headroom.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Cycles left to the block after the last result, to catch strays.
    localparam int DRAIN_CYCLES = 20;
    // Cycles of quiet before a register is written.
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;

    localparam longint STATE_MAX = 64'sd2147483647;
    localparam longint STATE_MIN = -64'sd2147483648;

    typedef enum int {
        CFG_ALL_MAX,
        CFG_ALL_MIN,
        CFG_MIXED_EXTREMES,
        CFG_TYPICAL,
        CFG_ANY
    } cfg_kind_t;

    typedef struct packed {
        logic [CODE_W-1:0] mult_code;
        logic [CODE_W-1:0] add_code;
        logic [CODE_W-1:0] channel;
        logic              first_step;
        logic              last_step;
    } pool_elem_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_channel;
        logic [CODE_W-1:0] step_code;
        logic [CODE_W-1:0] final_code;
        logic              final_valid;
    } pool_result_t;

    typedef struct packed {
        pool_elem_t   elem;
        logic         typed;
        pool_result_t want;
    } directed_row_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } reg_write_t;

    // Directed rows run under the reset settings: every scale is 1.0 and
    // every zero point is 0, so m and c equal the raw codes. Rows with typed
    // set carry a result worked out by hand; the rest go to the predictor.
    localparam int NUM_DIRECTED = 15;
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // First step on a fresh channel with zero codes gives zero.
        '{'{8'd0,   8'd0,   8'd0,   1'b1, 1'b0}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        // Old state zero times the largest multiplier leaves only c.
        '{'{8'd255, 8'd5,   8'd0,   1'b0, 1'b0}, 1'b1, '{8'd0,   8'd5,   8'd0,   1'b0}},
        // 5 * 1 + 3 on the last step, so the final code shows too.
        '{'{8'd1,   8'd3,   8'd0,   1'b0, 1'b1}, 1'b1, '{8'd0,   8'd8,   8'd8,   1'b1}},
        // First step ignores the stored 8.
        '{'{8'd1,   8'd9,   8'd0,   1'b1, 1'b1}, 1'b1, '{8'd0,   8'd9,   8'd9,   1'b1}},
        '{'{8'd200, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
        // 255 * 255 + 255 overflows Q15.16 and saturates the state.
        '{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
        // A zero multiplier wipes even the saturated state.
        '{'{8'd0,   8'd0,   8'd255, 1'b0, 1'b1}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b1}},
        '{'{8'd2,   8'd7,   8'd128, 1'b1, 1'b0}, 1'b1, '{8'd128, 8'd7,   8'd0,   1'b0}},
        // 7 * 128 is well above the output range and clips at 255.
        '{'{8'd128, 8'd0,   8'd128, 1'b0, 1'b0}, 1'b1, '{8'd128, 8'd255, 8'd0,   1'b0}},
        '{'{8'd0,   8'd255, 8'd1,   1'b1, 1'b1}, 1'b1, '{8'd1,   8'd255, 8'd255, 1'b1}},
        '{'{8'h55,  8'hAA,  8'h55,  1'b1, 1'b0}, 1'b1, '{8'h55,  8'd170, 8'd0,   1'b0}},
        '{'{8'hAA,  8'h55,  8'hAA,  1'b1, 1'b1}, 1'b1, '{8'hAA,  8'd85,  8'd85,  1'b1}},
        '{'{8'h55,  8'h0F,  8'h55,  1'b0, 1'b1}, 1'b0, '0},
        '{'{8'h80,  8'h80,  8'hAA,  1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h03,  8'h01,  8'd0,   1'b0, 1'b1}, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and of the channel state memory.
    logic [CFG_DATA_W-1:0] reg_shadow [NUM_REGS];
    int                    chan_state [DEPTH];

    pool_result_t pending_results [$];
    reg_write_t   pending_writes [$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    int unsigned  cycle_count = 0;

    // Sender burst bookkeeping and receiver stall pattern.
    int          burst_left = 0;
    logic [1:0]  sink_mode = 2'd0;
    int unsigned sink_hold = 0;

    quantized_linear_recurrence_pool dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is bounded so that a hung handshake or a lost result ends it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: the stall style is redrawn when cycle_count[8:0] is zero, among always
    // ready, coin flips, one cycle in four, and long on/off stretches.
    always @(posedge clk)
    begin
        if (cycle_count[8:0] == 9'd0)
            sink_mode <= 2'($urandom_range(0, 3));
        case (sink_mode)
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (cycle_count[1:0] == 2'd0);
            default:
            begin
                if (sink_hold == 0)
                begin
                    sink_hold <= $urandom_range(1, 24);
                    m_axis_tready <= !m_axis_tready;
                end
                else
                    sink_hold <= sink_hold - 1;
            end
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Each result transaction is compared field by field with the oldest
    // expectation. Signals are sampled at the edge, before any update lands.
    always @(posedge clk)
    begin
        pool_result_t got;
        pool_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_channel = m_axis_tdata[7:0];
            got.step_code = m_axis_tdata[15:8];
            got.final_code = m_axis_tdata[23:16];
            got.final_valid = m_axis_tuser[0];
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, channel", got.out_channel, -1);
            else
            begin
                want = pending_results.pop_front();
                if (got.out_channel != want.out_channel)
                    report_mismatch("out_channel", got.out_channel, want.out_channel);
                if (got.step_code != want.step_code)
                    report_mismatch("step_code", got.step_code, want.step_code);
                if (got.final_code != want.final_code)
                    report_mismatch("final_code", got.final_code, want.final_code);
                if (got.final_valid != want.final_valid)
                    report_mismatch("final_valid", got.final_valid, want.final_valid);
            end
            results_seen++;
        end
    end

    // a * b >> sh, rounding half away from zero on the magnitude. Both
    // operands stay small enough that the product fits in 63 bits.
    function automatic longint round_mul_shift(input longint a, input longint b,
                                               input int sh);
        bit                neg;
        longint unsigned   ua;
        longint unsigned   ub;
        longint unsigned   mag;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        mag = (ua * ub + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Q15.16 state times a Q8.16 reciprocal scale, rounded to an integer,
    // offset by the zero point and clipped to the uint8 range.
    function automatic logic [CODE_W-1:0] requantize_state(input int st,
                                                           input logic [SCALE_W-1:0] inv,
                                                           input logic [CODE_W-1:0] zp);
        longint inv_l;
        longint zp_l;
        longint v;
        inv_l = inv;
        zp_l = zp;
        v = round_mul_shift(longint'(st), inv_l, 32) + zp_l;
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // Predicts the result of one element and moves the channel state on.
    function automatic pool_result_t advance_channel_state(input pool_elem_t e);
        longint       mult_val;
        longint       add_val;
        longint       scale_m;
        longint       scale_a;
        longint       zero_m;
        longint       zero_a;
        longint       code_m;
        longint       code_a;
        longint       prev;
        longint       next_val;
        int           next_state;
        bit           in_range;
        pool_result_t r;
        scale_m = reg_shadow[REG_MULT_SCALE];
        zero_m = reg_shadow[REG_MULT_ZERO];
        scale_a = reg_shadow[REG_ADD_SCALE];
        zero_a = reg_shadow[REG_ADD_ZERO];
        code_m = e.mult_code;
        code_a = e.add_code;
        mult_val = (code_m - zero_m) * scale_m;
        add_val = (code_a - zero_a) * scale_a;
        in_range = int'(e.channel) < DEPTH;
        // The first step of a sequence starts from zero; so does a channel
        // the memory does not hold, which also keeps nothing afterwards.
        prev = 0;
        if (!e.first_step && in_range)
            prev = chan_state[e.channel];
        next_val = round_mul_shift(prev, mult_val, 16) + add_val;
        if (next_val > STATE_MAX)
            next_val = STATE_MAX;
        if (next_val < STATE_MIN)
            next_val = STATE_MIN;
        next_state = int'(next_val);
        if (in_range)
            chan_state[e.channel] = next_state;
        r.out_channel = e.channel;
        r.step_code = requantize_state(next_state, reg_shadow[REG_OUT_INV_SCALE],
                                       reg_shadow[REG_OUT_ZERO][CODE_W-1:0]);
        r.final_code = '0;
        if (e.last_step)
            r.final_code = requantize_state(next_state, reg_shadow[REG_FIN_INV_SCALE],
                                            reg_shadow[REG_FIN_ZERO][CODE_W-1:0]);
        r.final_valid = e.last_step;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_field_mask(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_MULT_ZERO, REG_ADD_ZERO, REG_OUT_ZERO, REG_FIN_ZERO: return 24'h0000FF;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // Sends all queued register writes back to back, updating the shadow
    // copy as each transaction completes. Unknown indexes change nothing.
    task automatic flush_reg_writes();
        reg_write_t w;
        while (pending_writes.size() != 0)
        begin
            w = pending_writes.pop_front();
            cfg_index <= w.index;
            cfg_data <= w.value;
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (int'(w.index) < NUM_REGS)
                reg_shadow[w.index] = w.value & reg_field_mask(w.index);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drives one element, waits for its input transaction and records what
    // should come back. The sender runs in bursts, most of them preceded by an idle gap.
    task automatic send_element(input pool_elem_t e, input logic typed,
                                input pool_result_t want);
        int           gap;
        pool_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata <= {e.channel, e.add_code, e.mult_code};
        s_axis_tuser <= e.first_step;
        s_axis_tlast <= e.last_step;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_channel_state(e);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Lowers the input valid and waits until every result has come back, so
    // the block is idle before its registers change.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_scale(input cfg_kind_t kind,
                                                         input int lo, input int hi);
        case (kind)
            CFG_ALL_MAX: return 24'hFFFFFF;
            CFG_ALL_MIN: return '0;
            CFG_MIXED_EXTREMES:
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return 24'hFFFFFF;
                    default: return SCALE_ONE;
                endcase
            CFG_TYPICAL: return 24'($urandom_range(lo, hi));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_zero(input cfg_kind_t kind);
        case (kind)
            CFG_ALL_MAX: return 24'h0000FF;
            CFG_ALL_MIN: return '0;
            CFG_MIXED_EXTREMES:
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return 24'h0000FF;
                    default: return 24'h000080;
                endcase
            CFG_TYPICAL: return 24'($urandom_range(0, 255));
            // Upper bits set here must be dropped by the 8-bit registers.
            default: return 24'($urandom);
        endcase
    endfunction

    // Queues one write of every register. The typical setting keeps the
    // multiplier near +-1 around a mid zero point so that the recurrence
    // neither dies out nor saturates at once.
    task automatic queue_setting(input cfg_kind_t kind);
        pending_writes.push_back('{REG_MULT_SCALE, pick_scale(kind, 256, 1024)});
        pending_writes.push_back('{REG_MULT_ZERO,
                                  (kind == CFG_TYPICAL) ? 24'($urandom_range(100, 156))
                                                        : pick_zero(kind)});
        pending_writes.push_back('{REG_ADD_SCALE, pick_scale(kind, 1 << 10, 1 << 18)});
        pending_writes.push_back('{REG_ADD_ZERO, pick_zero(kind)});
        pending_writes.push_back('{REG_OUT_INV_SCALE, pick_scale(kind, 1 << 8, 1 << 20)});
        pending_writes.push_back('{REG_OUT_ZERO, pick_zero(kind)});
        pending_writes.push_back('{REG_FIN_INV_SCALE, pick_scale(kind, 1 << 8, 1 << 20)});
        pending_writes.push_back('{REG_FIN_ZERO, pick_zero(kind)});
    endtask

    function automatic logic [CODE_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 8'd255;
            2, 3: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random elements, mostly as proper time sequences: one to four channels
    // interleaved, the first step flagged at the start and the last step at
    // the end. The rest is noise with every field random.
    task automatic run_random_elements(input int count);
        int           sent;
        int           n_chan;
        int           steps;
        logic [CODE_W-1:0] chans [4];
        pool_elem_t   e;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n_chan = $urandom_range(1, 4);
                steps = $urandom_range(1, 10);
                for (int k = 0; k < n_chan; k++)
                    chans[k] = pick_channel();
                for (int t = 0; t < steps; t++)
                begin
                    for (int k = 0; k < n_chan; k++)
                    begin
                        e.mult_code = 8'($urandom_range(0, 255));
                        e.add_code = 8'($urandom_range(0, 255));
                        e.channel = chans[k];
                        e.first_step = (t == 0);
                        e.last_step = (t == steps - 1);
                        send_element(e, 1'b0, '0);
                        sent++;
                    end
                end
            end
            else
            begin
                e = pool_elem_t'($urandom);
                send_element(e, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        cfg_kind_t kind;
        reg_shadow[REG_MULT_SCALE] = SCALE_ONE;
        reg_shadow[REG_MULT_ZERO] = '0;
        reg_shadow[REG_ADD_SCALE] = SCALE_ONE;
        reg_shadow[REG_ADD_ZERO] = '0;
        reg_shadow[REG_OUT_INV_SCALE] = SCALE_ONE;
        reg_shadow[REG_OUT_ZERO] = '0;
        reg_shadow[REG_FIN_INV_SCALE] = SCALE_ONE;
        reg_shadow[REG_FIN_ZERO] = '0;
        for (int i = 0; i < DEPTH; i++)
            chan_state[i] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Writes to indexes past the list must not disturb the reset values
        // that the directed table relies on.
        pending_writes.push_back('{REG_BEYOND_LIST, 24'h000000});
        pending_writes.push_back('{REG_TOP_INDEX, 24'hFFFFFF});
        flush_reg_writes();

        foreach (directed_rows[i])
            send_element(directed_rows[i].elem, directed_rows[i].typed,
                         directed_rows[i].want);
        drain_block();

        // The first two phases pin every register at its extremes; the
        // rest favor realistic settings with a share of odd ones.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0)
                kind = CFG_ALL_MAX;
            else if (phase == 1)
                kind = CFG_ALL_MIN;
            else
                case ($urandom_range(0, 4))
                    0: kind = CFG_MIXED_EXTREMES;
                    1: kind = CFG_ANY;
                    default: kind = CFG_TYPICAL;
                endcase
            queue_setting(kind);
            flush_reg_writes();
            run_random_elements(ITEMS_PER_PHASE);
            drain_block();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- quantized_linear_recurrence_pool.f -----
rtl/qlrp_pkg.sv
rtl/qlrp_cfg.sv
rtl/qlrp_ctrl.sv
rtl/qlrp_dp.sv
rtl/quantized_linear_recurrence_pool.sv
rtl/qlrp_checker.sv
bench/tb_quantized_linear_recurrence_pool.sv
